@@ src/sfc_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// sfc_pkg
// Types, constants and the crc helper shared by the frame check and reply block.
// ----------------------------------------------------------------------------
package sfc_pkg;

  localparam int unsigned MaxFrame = 256;
  localparam int unsigned CntW     = $clog2(MaxFrame + 1);

  localparam logic [15:0] CrcInit  = 16'hFFFF;
  localparam logic [15:0] CrcPoly  = 16'hA001;

  localparam logic [7:0]  HdrFirstRst  = 8'h55;
  localparam logic [7:0]  HdrSecondRst = 8'hAA;

  localparam logic [7:0]  ReplyType    = 8'h01;
  localparam logic [7:0]  HbCmd        = 8'h00;
  localparam logic [7:0]  EchoCmd      = 8'h05;
  localparam logic [7:0]  CmdRead      = 8'h03;
  localparam logic [7:0]  CmdWrite     = 8'h04;
  localparam logic [7:0]  EchoLenHi    = 8'h00;
  localparam logic [7:0]  EchoLenLo    = 8'h06;
  localparam logic [15:0] EchoLen      = 16'd6;
  localparam int unsigned MinFrame     = 8;

  localparam logic CfgHdrFirst  = 1'b0;
  localparam logic CfgHdrSecond = 1'b1;

  typedef enum logic [1:0] {
    ACT_BYTE   = 2'd0,
    ACT_LAST   = 2'd1,
    ACT_UPDATE = 2'd2,
    ACT_NONE   = 2'd3
  } sfc_action_e;

  typedef struct packed {
    logic [1:0] action;
    logic [7:0] rx_byte;
  } sfc_in_t;

  typedef struct packed {
    logic [7:0] tx_byte;
    logic       end_of_reply;
    logic [7:0] last_command;
  } sfc_out_t;

  typedef struct packed {
    logic            hb;
    logic            echo;
    logic [7:0]      cmd;
    logic [7:0]      hdr0;
    logic [7:0]      hdr1;
    logic [5:0][7:0] pay;
  } sfc_job_t;

  function automatic logic [15:0] crc_feed(input logic [15:0] c_in, input logic [7:0] b);
    logic [15:0] c;
    c = c_in ^ {8'h00, b};
    for (int k = 0; k < 8; k++) begin
      if (c[0]) c = (c >> 1) ^ CrcPoly;
      else      c = c >> 1;
    end
    return c;
  endfunction

endpackage
`default_nettype wire

@@ src/sfc_front.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// sfc_front
// Takes frame beats, tracks crc and length, checks each frame at its end and
// queues reply jobs.
// ----------------------------------------------------------------------------
module sfc_front
  import sfc_pkg::*;
(
  input  wire logic     clk_i,
  input  wire logic     rst_ni,
  input  wire logic     in_valid_i,
  input  wire sfc_in_t  in_data_i,
  output logic          in_stall_o,
  input  wire logic     cfg_we_i,
  input  wire logic     cfg_idx_i,
  input  wire logic [7:0] cfg_data_i,
  output logic          job_valid_o,
  output sfc_job_t      job_o,
  input  wire logic     job_full_i
);

  logic [7:0]      hdr0_q, hdr1_q;
  logic [15:0]     crc_q, crc_d;
  logic [CntW-1:0] cnt_q, cnt_d;
  logic            tl_q, tl_d;
  logic [5:0][7:0] head_q, pay_q;
  logic [7:0]      dly0_q, dly1_q;
  logic            pend_q, pend_d;
  logic [7:0]      cmd_q, cmd_d;

  logic accept, is_frame, is_last, stored;
  logic hdr_ok, type0, len_ok, crc_ok, cmd_ok;
  logic [15:0] plen;
  logic hb, echo, done_ok;

  assign in_stall_o = job_full_i;
  assign accept     = in_valid_i && !job_full_i;
  assign is_frame   = (in_data_i.action == ACT_BYTE) || (in_data_i.action == ACT_LAST);
  assign is_last    = in_data_i.action == ACT_LAST;
  assign stored     = cnt_q < CntW'(MaxFrame);

  always_comb begin
    crc_d = crc_q;
    cnt_d = cnt_q;
    tl_d  = tl_q;
    if (stored) begin
      if (cnt_q >= CntW'(2)) crc_d = crc_feed(crc_q, dly0_q);
      cnt_d = cnt_q + CntW'(1);
    end else begin
      tl_d = 1'b1;
    end
  end

  assign plen    = {head_q[4], head_q[5]};
  assign hdr_ok  = (head_q[0] == hdr0_q) && (head_q[1] == hdr1_q);
  assign type0   = head_q[2] == 8'h00;
  assign done_ok = !tl_d && (cnt_d >= CntW'(MinFrame)) && hdr_ok;
  assign len_ok  = ({1'b0, plen} + 17'd8) == 17'(cnt_d);
  assign crc_ok  = {dly1_q, in_data_i.rx_byte} == crc_d;
  assign cmd_ok  = (head_q[3] == CmdRead) || (head_q[3] == CmdWrite);
  assign hb      = done_ok && type0 && !pend_q;
  assign echo    = done_ok && !(type0 && pend_q) && len_ok && crc_ok && cmd_ok
                   && (plen == EchoLen);

  always_comb begin
    pend_d = pend_q;
    cmd_d  = cmd_q;
    if (accept && in_data_i.action == ACT_UPDATE) pend_d = 1'b1;
    if (accept && is_last && done_ok) begin
      if (type0 && pend_q) pend_d = 1'b0;
      else cmd_d = head_q[3];
    end
  end

  assign job_valid_o = accept && is_last && (hb || echo);
  always_comb begin
    job_o.hb   = hb;
    job_o.echo = echo;
    job_o.cmd  = cmd_d;
    job_o.hdr0 = hdr0_q;
    job_o.hdr1 = hdr1_q;
    job_o.pay  = pay_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hdr0_q <= HdrFirstRst;
      hdr1_q <= HdrSecondRst;
      crc_q  <= CrcInit;
      cnt_q  <= '0;
      tl_q   <= 1'b0;
      pend_q <= 1'b0;
      cmd_q  <= '0;
    end else begin
      if (cfg_we_i) begin
        if (cfg_idx_i == CfgHdrFirst) hdr0_q <= cfg_data_i;
        if (cfg_idx_i == CfgHdrSecond) hdr1_q <= cfg_data_i;
      end
      pend_q <= pend_d;
      cmd_q  <= cmd_d;
      if (accept && is_frame) begin
        if (is_last) begin
          crc_q <= CrcInit;
          cnt_q <= '0;
          tl_q  <= 1'b0;
        end else begin
          crc_q <= crc_d;
          cnt_q <= cnt_d;
          tl_q  <= tl_d;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept && is_frame && stored) begin
      if (cnt_q < CntW'(6)) head_q[cnt_q[2:0]] <= in_data_i.rx_byte;
      else if (cnt_q < CntW'(12)) pay_q[3'(cnt_q - CntW'(6))] <= in_data_i.rx_byte;
      dly0_q <= dly1_q;
      dly1_q <= in_data_i.rx_byte;
    end
  end

endmodule
`default_nettype wire

@@ src/sfc_fifo.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// sfc_fifo
// Two-entry job queue between the checking front and the reply back end.
// ----------------------------------------------------------------------------
module sfc_fifo
  import sfc_pkg::*;
(
  input  wire logic     clk_i,
  input  wire logic     rst_ni,
  input  wire logic     push_i,
  input  wire sfc_job_t push_data_i,
  output logic          full_o,
  input  wire logic     pop_i,
  output logic          valid_o,
  output sfc_job_t      pop_data_o
);

  sfc_job_t   mem_q [2];
  logic       wr_q, rd_q;
  logic [1:0] cnt_q;
  logic       do_push, do_pop;

  assign full_o     = cnt_q == 2'd2;
  assign valid_o    = cnt_q != 2'd0;
  assign pop_data_o = mem_q[rd_q];
  assign do_push    = push_i && !full_o;
  assign do_pop     = pop_i && valid_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= 1'b0;
      rd_q  <= 1'b0;
      cnt_q <= 2'd0;
    end else begin
      if (do_push) wr_q <= !wr_q;
      if (do_pop) rd_q <= !rd_q;
      if (do_push && !do_pop) cnt_q <= cnt_q + 2'd1;
      else if (do_pop && !do_push) cnt_q <= cnt_q - 2'd1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) mem_q[wr_q] <= push_data_i;
  end

endmodule
`default_nettype wire

@@ src/sfc_back.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// sfc_back
// Plays out heartbeat and echo replies one byte per beat with a fresh crc.
// ----------------------------------------------------------------------------
module sfc_back
  import sfc_pkg::*;
(
  input  wire logic     clk_i,
  input  wire logic     rst_ni,
  input  wire logic     job_valid_i,
  input  wire sfc_job_t job_i,
  output logic          job_pop_o,
  output logic          out_valid_o,
  output sfc_out_t      out_data_o,
  input  wire logic     out_stall_i
);

  sfc_job_t    job_q;
  logic        busy_q, seg_q;
  logic [3:0]  idx_q;
  logic [15:0] crc_q;
  logic        ov_q;
  sfc_out_t    od_q;

  logic        adv, step;
  logic [3:0]  blen;
  logic [7:0]  body;
  logic [7:0]  byte_v;
  logic        seg_end;

  assign adv       = !ov_q || !out_stall_i;
  assign step      = busy_q && adv;
  assign job_pop_o = !busy_q && job_valid_i;
  assign blen      = seg_q ? 4'd12 : 4'd4;

  always_comb begin
    case (idx_q)
      4'd0:    body = job_q.hdr0;
      4'd1:    body = job_q.hdr1;
      4'd2:    body = ReplyType;
      4'd3:    body = seg_q ? EchoCmd : HbCmd;
      4'd4:    body = EchoLenHi;
      4'd5:    body = EchoLenLo;
      4'd6:    body = job_q.pay[0];
      4'd7:    body = job_q.pay[1];
      4'd8:    body = job_q.pay[2];
      4'd9:    body = job_q.pay[3];
      4'd10:   body = job_q.pay[4];
      4'd11:   body = job_q.pay[5];
      default: body = 8'h00;
    endcase
  end

  always_comb begin
    seg_end = 1'b0;
    if (idx_q < blen) byte_v = body;
    else if (idx_q == blen) byte_v = crc_q[15:8];
    else begin
      byte_v  = crc_q[7:0];
      seg_end = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      ov_q   <= 1'b0;
    end else begin
      if (adv) ov_q <= step;
      if (job_pop_o) busy_q <= 1'b1;
      else if (step && seg_end && (seg_q || !job_q.echo)) busy_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (job_pop_o) begin
      job_q <= job_i;
      seg_q <= !job_i.hb;
      idx_q <= 4'd0;
      crc_q <= CrcInit;
    end else if (step) begin
      if (seg_end) begin
        seg_q <= 1'b1;
        idx_q <= 4'd0;
        crc_q <= CrcInit;
      end else begin
        idx_q <= idx_q + 4'd1;
        if (idx_q < blen) crc_q <= crc_feed(crc_q, body);
      end
    end
    if (step) begin
      od_q.tx_byte      <= byte_v;
      od_q.end_of_reply <= seg_end;
      od_q.last_command <= job_q.cmd;
    end
  end

  assign out_valid_o = ov_q;
  assign out_data_o  = od_q;

endmodule
`default_nettype wire

@@ src/serial_frame_check_and_reply.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// serial_frame_check_and_reply
// Checks framed serial input with crc-16/modbus and sends heartbeat and echo
// replies.
// ----------------------------------------------------------------------------
// An input beat is taken per cycle unless in_stall_o is high. A passing frame
// queues a reply job in a two-entry queue; the reply side sends one byte per
// cycle unless out_stall_i is high, 6 bytes for a heartbeat, 14 for an echo,
// 20 for both, so the input stalls only while both entries hold waiting jobs.
module serial_frame_check_and_reply
  import sfc_pkg::*;
(
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  wire logic       in_valid_i,
  input  wire sfc_in_t    in_data_i,
  output logic            in_stall_o,
  output logic            out_valid_o,
  output sfc_out_t        out_data_o,
  input  wire logic       out_stall_i,
  input  wire logic       cfg_we_i,
  input  wire logic       cfg_idx_i,
  input  wire logic [7:0] cfg_data_i
);

  logic     push, full, pop, qvalid;
  sfc_job_t push_job, pop_job;

  sfc_front u_front (
    .clk_i, .rst_ni, .in_valid_i, .in_data_i, .in_stall_o,
    .cfg_we_i, .cfg_idx_i, .cfg_data_i,
    .job_valid_o (push),
    .job_o       (push_job),
    .job_full_i  (full)
  );

  sfc_fifo u_fifo (
    .clk_i, .rst_ni,
    .push_i      (push),
    .push_data_i (push_job),
    .full_o      (full),
    .pop_i       (pop),
    .valid_o     (qvalid),
    .pop_data_o  (pop_job)
  );

  sfc_back u_back (
    .clk_i, .rst_ni,
    .job_valid_i (qvalid),
    .job_i       (pop_job),
    .job_pop_o   (pop),
    .out_valid_o, .out_data_o, .out_stall_i
  );

endmodule
`default_nettype wire
